### src/cir_pkg.sv
`default_nettype none

package cir_pkg;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int WIN_W     = 24;
  localparam int STEP_W    = 25;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 25;

  // Coefficient widths: c0 peaks near 4205, c1 spans 0..65536
  localparam int C0_W      = 13;
  localparam int C1_W      = 17;
  localparam longint unsigned COEF_ONE = 64'd65536;

  // Averaging divider: dividend 512*sum + have + have*2^25 stays below 2^34
  localparam int DIVD_W     = 34;
  localparam int DEN_W      = 10;
  localparam int DIV_STEPS  = 34;
  localparam int DIV_CNT_W  = 6;
  localparam int PT_SHIFT   = 9;
  localparam int BIAS_SHIFT = 25;

  // Output rounding and saturation
  localparam int ROUND_SHIFT = 16;
  localparam logic [WIN_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [WIN_W-1:0] OUT_MIN = 24'h800000;

  // Queue depth between stages and at the output
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT = 1'b1;

  // Register file contents seen by both halves
  typedef struct packed {
    logic [STEP_W-1:0] phase_step;
    logic [CNT_W-1:0]  average_count;
  } cir_cfg_t;

  // c0[i] = round((p - p^3)/6 * 65536), p = i / 2^tb
  function automatic logic [C0_W-1:0] coef0_at(input int unsigned i, input int unsigned tb);
    longint unsigned n;
    longint unsigned li;
    longint unsigned num;
    longint unsigned r;
    n  = 64'd1 << tb;
    li = 64'(i);
    if (li == 64'd0 || li >= n) begin
      return '0;
    end
    num = (li * n * n - li * li * li) * COEF_ONE;
    // divide by 6*n^3: shift out 2*n^3, then divide by three
    r = ((num + (64'd3 << (3 * tb))) >> (3 * tb + 1)) / 3;
    return C0_W'(r);
  endfunction

  // c1 on the lower half of the table
  function automatic longint unsigned coef1_base(input int unsigned i, input int unsigned tb);
    longint unsigned n;
    longint unsigned li;
    longint unsigned num;
    n   = 64'd1 << tb;
    li  = 64'(i);
    num = (64'd2 * li * n * n + li * li * n - li * li * li) * COEF_ONE;
    return (num + (64'd1 << (3 * tb))) >> (3 * tb + 1);
  endfunction

  // c1 over the whole table; the upper half keeps the taps summing to one
  function automatic logic [C1_W-1:0] coef1_at(input int unsigned i, input int unsigned tb);
    longint unsigned n;
    longint unsigned r;
    n = 64'd1 << tb;
    if (i == 0) begin
      r = 64'd0;
    end else if (64'(i) >= n) begin
      r = COEF_ONE;
    end else if (64'(i) <= (n >> 1)) begin
      r = coef1_base(i, tb);
    end else begin
      r = COEF_ONE + 64'(coef0_at(i, tb)) + 64'(coef0_at(int'(n) - i, tb))
          - coef1_base(int'(n) - i, tb);
    end
    return C1_W'(r);
  endfunction

endpackage

`default_nettype wire

### src/cir_fifo.sv
`default_nettype none

module cir_fifo #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fifo count above depth");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == CNT_W'($past(count) + 1'b1)))
    else $error("fifo count did not grow on a lone write");

endmodule

`default_nettype wire

### src/cir_front.sv
`default_nettype none

module cir_front (
  input  logic                           clk,
  input  logic                           rst,
  input  cir_pkg::cir_cfg_t              cfg,
  input  logic                           push,
  output logic                           full,
  input  logic signed [cir_pkg::SAMPLE_W-1:0] native_sample,
  output logic                           pt_push,
  output logic [cir_pkg::WIN_W-1:0]      pt_data,
  input  logic                           pt_full
);

  import cir_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t          state;
  logic signed [WIN_W-1:0] avg_sum;
  logic [CNT_W-1:0]      avg_seen;
  logic [DIVD_W-1:0]     dvd;
  logic [DEN_W-1:0]      den;
  logic [DEN_W-2:0]      rem;
  logic [WIN_W-1:0]      quo;
  logic [DIV_CNT_W-1:0]  step_cnt;

  logic                  accept;
  logic [CNT_W-1:0]      cnt_eff;
  logic [CNT_W:0]        have;
  logic signed [WIN_W-1:0] sum_next;
  logic                  grp_done;
  logic [DIVD_W-1:0]     dvd_init;
  logic [DEN_W-1:0]      trial;
  logic [DEN_W-1:0]      diff;
  logic                  qbit;

  assign full   = (state != F_IDLE);
  assign accept = push && (state == F_IDLE);

  // Group bookkeeping; a zero count behaves as one
  assign cnt_eff  = (cfg.average_count == '0) ? CNT_W'(1) : cfg.average_count;
  assign have     = {1'b0, avg_seen} + 1'b1;
  assign sum_next = avg_sum + WIN_W'(native_sample);
  assign grp_done = (have >= {1'b0, cnt_eff});

  // Biased dividend keeps the numerator positive; the bias drops out of the low bits
  assign dvd_init = {{(DIVD_W - WIN_W - PT_SHIFT){sum_next[WIN_W-1]}}, sum_next,
                     {PT_SHIFT{1'b0}}}
                    + DIVD_W'(have) + (DIVD_W'(have) << BIAS_SHIFT);

  // One restoring division step
  assign trial = {rem, dvd[DIVD_W-1]};
  assign diff  = trial - den;
  assign qbit  = (trial >= den);

  assign pt_push = (state == F_PUSH) && !pt_full;
  assign pt_data = quo;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      avg_sum  <= '0;
      avg_seen <= '0;
      step_cnt <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (grp_done) begin
              avg_sum  <= '0;
              avg_seen <= '0;
              step_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
              state    <= F_DIV;
            end else begin
              avg_sum  <= sum_next;
              avg_seen <= have[CNT_W-1:0];
            end
          end
        end
        F_DIV: begin
          step_cnt <= step_cnt - 1'b1;
          if (step_cnt == '0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!pt_full) begin
            state <= F_IDLE;
          end
        end
      endcase
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (accept && grp_done) begin
      dvd <= dvd_init;
      den <= {have, 1'b0};
      rem <= '0;
      quo <= '0;
    end else if (state == F_DIV) begin
      dvd <= {dvd[DIVD_W-2:0], 1'b0};
      rem <= qbit ? diff[DEN_W-2:0] : trial[DEN_W-2:0];
      quo <= {quo[WIN_W-2:0], qbit};
    end
  end

  a_group_starts_div: assert property (@(posedge clk) disable iff (rst)
    (accept && grp_done) |=> (state == F_DIV && full))
    else $error("completed group did not start the divider");

endmodule

`default_nettype wire

### src/cir_back.sv
`default_nettype none

module cir_back #(
  parameter int PHASE_BITS = 24,
  parameter int TABLE_BITS = 12,
  parameter int MAX_RUN    = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cir_pkg::cir_cfg_t         cfg,
  input  logic                      pt_empty,
  input  logic [cir_pkg::WIN_W-1:0] pt_data,
  output logic                      pt_pop,
  input  logic                      res_full,
  output logic                      res_push,
  output logic [cir_pkg::WIN_W-1:0] res_sample,
  output logic                      res_last
);

  import cir_pkg::*;

  localparam int TAB_N  = 1 << TABLE_BITS;
  localparam int RUN_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int SUM_W  = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;
  localparam int CS_W   = C1_W + 1;
  localparam int PROD_W = WIN_W + CS_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int Q_W    = ACC_W - ROUND_SHIFT;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_FETCH = 4'b0010,
    B_MAC   = 4'b0100,
    B_EMIT  = 4'b1000
  } back_state_t;

  back_state_t             state;
  logic [PHASE_BITS-1:0]   phase_acc;
  logic signed [WIN_W-1:0] win_oldest;
  logic signed [WIN_W-1:0] win_second;
  logic signed [WIN_W-1:0] win_third;
  logic signed [WIN_W-1:0] win_newest;
  logic [WIN_W-1:0]        point;
  logic [RUN_W-1:0]        run_cnt;
  logic [2:0]              tap;

  // Coefficient ROMs, two read ports each
  logic [C0_W-1:0]         rom0 [TAB_N + 1];
  logic [C1_W-1:0]         rom1 [TAB_N + 1];
  logic [C0_W-1:0]         c0k;
  logic [C0_W-1:0]         c0m;
  logic [C1_W-1:0]         c1k;
  logic [C1_W-1:0]         c1m;
  logic [TABLE_BITS:0]     idx_k;
  logic [TABLE_BITS:0]     idx_m;

  logic signed [WIN_W-1:0]  mul_a;
  logic [C1_W-1:0]          mul_c;
  logic                     mul_neg;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_neg;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [Q_W-1:0]    q;
  logic                     ovf_hi;
  logic                     ovf_lo;

  logic [SUM_W-1:0]         sum;
  logic                     wrap;
  logic                     last;

  for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_rom
    assign rom0[gi] = coef0_at(gi, TABLE_BITS);
    assign rom1[gi] = coef1_at(gi, TABLE_BITS);
  end

  // Table index from the top phase bits and its mirror
  assign idx_k = {1'b0, phase_acc[PHASE_BITS-1 -: TABLE_BITS]};
  assign idx_m = (TABLE_BITS + 1)'(TAB_N) - idx_k;

  always_ff @(posedge clk) begin
    c0k <= rom0[idx_k];
    c0m <= rom0[idx_m];
    c1k <= rom1[idx_k];
    c1m <= rom1[idx_m];
  end

  // Tap select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_c   = '0;
    mul_neg = 1'b0;
    case (tap)
      3'd0: begin
        mul_a   = win_oldest;
        mul_c   = C1_W'(c0m);
        mul_neg = 1'b1;
      end
      3'd1: begin
        mul_a = win_second;
        mul_c = c1m;
      end
      3'd2: begin
        mul_a = win_third;
        mul_c = c1k;
      end
      3'd3: begin
        mul_a   = win_newest;
        mul_c   = C1_W'(c0k);
        mul_neg = 1'b1;
      end
      default: begin
        mul_a   = '0;
        mul_c   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign term = prod_neg ? -ACC_W'(prod) : ACC_W'(prod);

  // Round half up, then clamp to 24 bits
  assign rnd    = acc + ACC_W'(1 << (ROUND_SHIFT - 1));
  assign q      = rnd[ACC_W-1:ROUND_SHIFT];
  assign ovf_hi = !q[Q_W-1] && (|q[Q_W-2:WIN_W-1]);
  assign ovf_lo = q[Q_W-1] && !(&q[Q_W-2:WIN_W-1]);

  assign res_sample = ovf_hi ? OUT_MAX : (ovf_lo ? OUT_MIN : q[WIN_W-1:0]);

  // Phase advance; carry or MAX_RUN limit ends the run
  assign sum      = SUM_W'(phase_acc) + SUM_W'(cfg.phase_step);
  assign wrap     = |sum[SUM_W-1:PHASE_BITS];
  assign last     = wrap || (run_cnt == RUN_W'(MAX_RUN - 1));
  assign res_last = last;

  assign pt_pop   = (state == B_IDLE) && !pt_empty;
  assign res_push = (state == B_EMIT) && !res_full;

  // Multiply-accumulate datapath
  always_ff @(posedge clk) begin
    prod     <= mul_a * $signed({1'b0, mul_c});
    prod_neg <= mul_neg;
    if (state == B_MAC) begin
      if (tap == 3'd0) begin
        acc <= '0;
      end else begin
        acc <= acc + term;
      end
    end
    if (pt_pop) begin
      point <= pt_data;
    end
  end

  // Sequencer, phase and window
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      phase_acc  <= '0;
      win_oldest <= '0;
      win_second <= '0;
      win_third  <= '0;
      win_newest <= '0;
      run_cnt    <= '0;
      tap        <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pt_pop) begin
            state <= B_FETCH;
          end
        end
        B_FETCH: begin
          tap   <= '0;
          state <= B_MAC;
        end
        B_MAC: begin
          tap <= tap + 1'b1;
          if (tap == 3'd4) begin
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (res_push) begin
            phase_acc <= sum[PHASE_BITS-1:0];
            if (last) begin
              win_oldest <= win_second;
              win_second <= win_third;
              win_third  <= win_newest;
              win_newest <= point;
              run_cnt    <= '0;
              state      <= B_IDLE;
            end else begin
              run_cnt <= run_cnt + 1'b1;
              state   <= B_FETCH;
            end
          end
        end
      endcase
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_last) |=> (state == B_IDLE && run_cnt == '0))
    else $error("run did not end after its last transfer");

  a_phase_holds: assert property (@(posedge clk) disable iff (rst)
    !res_push |=> $stable(phase_acc))
    else $error("phase moved without an output transfer");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_cnt <= RUN_W'(MAX_RUN - 1))
    else $error("run count past its limit");

endmodule

`default_nettype wire

### src/cubic_interp_resampler_core.sv
// Groups: a sample that completes a group holds full through the 34 divider steps
//   and the hand-off, longer while the point queue is full; with the back end idle
//   its first output then passes the point queue, ROM read, taps and result queue.
// Outputs: each output goes in turn through the shared 24x18 multiplier (ROM read,
//   four taps plus drain, emit); each emit waits while the result queue is full.
// Samples that do not complete a group are accepted back to back while full is low.
// Reset (rst, synchronous, active high) clears phase, window, averaging and queues.
`default_nettype none

module cubic_interp_resampler_core #(
  parameter int PHASE_BITS = 24,
  parameter int TABLE_BITS = 12,
  parameter int MAX_RUN    = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [cir_pkg::SAMPLE_W-1:0] native_sample,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [cir_pkg::WIN_W-1:0]  out_sample,
  output logic                              run_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cir_pkg::CFG_DAT_W-1:0]     cfg_data
);

  import cir_pkg::*;

  cir_cfg_t         cfg;
  logic             pt_push;
  logic [WIN_W-1:0] pt_wdata;
  logic             pt_full;
  logic             pt_pop;
  logic [WIN_W-1:0] pt_rdata;
  logic             pt_empty;
  logic             res_push;
  logic [WIN_W-1:0] res_sample;
  logic             res_last;
  logic             res_full;
  logic [WIN_W:0]   res_rdata;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step    <= STEP_W'(1 << 24);
      cfg.average_count <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_STEP:    cfg.phase_step    <= cfg_data[STEP_W-1:0];
        REG_AVERAGE_COUNT: cfg.average_count <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  // Averaging front end
  cir_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .full          (full),
    .native_sample (native_sample),
    .pt_push       (pt_push),
    .pt_data       (pt_wdata),
    .pt_full       (pt_full)
  );

  // Source points waiting for the interpolator
  cir_fifo #(
    .WIDTH (WIN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_pt_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (pt_push),
    .wr_data (pt_wdata),
    .full    (pt_full),
    .rd      (pt_pop),
    .rd_data (pt_rdata),
    .empty   (pt_empty)
  );

  // Interpolation back end
  cir_back #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS),
    .MAX_RUN    (MAX_RUN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pt_empty   (pt_empty),
    .pt_data    (pt_rdata),
    .pt_pop     (pt_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_sample (res_sample),
    .res_last   (res_last)
  );

  // Result queue toward the consumer
  cir_fifo #(
    .WIDTH (WIN_W + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data ({res_last, res_sample}),
    .full    (res_full),
    .rd      (pop),
    .rd_data (res_rdata),
    .empty   (empty)
  );

  assign out_sample = res_rdata[WIN_W-1:0];
  assign run_last   = res_rdata[WIN_W];

endmodule

`default_nettype wire
